// File: hw/rtl/fbpa_pkg.sv
package fbpa_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int PTR_BYTES  = 4;

    localparam int ADDR_W = 32;
    localparam int SIZE_W = 16;
    localparam int CNT_W  = 9;
    localparam int ST_W   = 2;
    localparam int APB_AW = 4;

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int LINK_W = $clog2(MAX_BLOCKS + 1);
    localparam int WIDE_W = (LINK_W > CNT_W) ? LINK_W : CNT_W;
    localparam int PROD_W = WIDE_W + SIZE_W;
    localparam int DIVC_W = $clog2(CNT_W + 1);

    localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_BLOCKS);

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_INVAL = 2'd1;
    localparam logic [ST_W-1:0] ST_BUSY  = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_SIZE  = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] size;
        logic [CNT_W-1:0]  count;
    } fbpa_cfg_t;

    typedef struct packed {
        logic            latch;
        logic            bld_step;
        logic            mem_rd;
        logic            pop;
        logic            chk_setup;
        logic            div_start;
        logic            div_step;
        logic            walk_start;
        logic            walk_step;
        logic            push;
        logic            finish;
        logic [ST_W-1:0] code;
    } fbpa_cmd_t;

    typedef struct packed {
        logic addr_zero;
        logic cfg_ok;
        logic ready;
        logic bld_last;
        logic head_nil;
        logic range_bad;
        logic div_last;
        logic div_bad;
        logic walk_end;
        logic walk_hit;
        logic total_full;
    } fbpa_sts_t;

endpackage

// File: hw/rtl/fbpa_ctrl.sv
module fbpa_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  action,
    input  fbpa_pkg::fbpa_sts_t   sts,
    output fbpa_pkg::fbpa_cmd_t   cmd,
    output logic                  busy
);
    import fbpa_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_BUILD     = 3'd1;
    localparam logic [2:0] S_DISP      = 3'd2;
    localparam logic [2:0] S_ALLOC_POP = 3'd3;
    localparam logic [2:0] S_FREE_CHK  = 3'd4;
    localparam logic [2:0] S_DIV       = 3'd5;
    localparam logic [2:0] S_DIV_CHK   = 3'd6;
    localparam logic [2:0] S_WALK      = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       act_reg;
    logic       act_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            act_reg   <= ACT_ALLOC;
        end
        else
        begin
            state_reg <= state_next;
            act_reg   <= act_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        act_next   = act_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch = 1'b1;
                    act_next  = action;
                    if (action == ACT_FREE && sts.addr_zero)
                    begin
                        cmd.finish = 1'b1;
                        cmd.code   = ST_INVAL;
                    end
                    else if (!sts.ready)
                    begin
                        if (!sts.cfg_ok)
                        begin
                            cmd.finish = 1'b1;
                            cmd.code   = ST_INVAL;
                        end
                        else
                        begin
                            state_next = S_BUILD;
                        end
                    end
                    else
                    begin
                        state_next = S_DISP;
                    end
                end
            end
            S_BUILD:
            begin
                cmd.bld_step = 1'b1;
                if (sts.bld_last)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (act_reg == ACT_ALLOC)
                begin
                    if (sts.head_nil)
                    begin
                        cmd.finish = 1'b1;
                        cmd.code   = ST_BUSY;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.mem_rd = 1'b1;
                        state_next = S_ALLOC_POP;
                    end
                end
                else
                begin
                    cmd.chk_setup = 1'b1;
                    state_next    = S_FREE_CHK;
                end
            end
            S_ALLOC_POP:
            begin
                cmd.pop    = 1'b1;
                cmd.finish = 1'b1;
                cmd.code   = ST_OK;
                state_next = S_IDLE;
            end
            S_FREE_CHK:
            begin
                if (sts.range_bad)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = ST_INVAL;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_DIV_CHK;
                end
            end
            S_DIV_CHK:
            begin
                if (sts.div_bad)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = ST_INVAL;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_WALK;
                end
            end
            S_WALK:
            begin
                if (sts.walk_end)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                    if (sts.total_full)
                    begin
                        cmd.code = ST_INVAL;
                    end
                    else
                    begin
                        cmd.push = 1'b1;
                        cmd.code = ST_OK;
                    end
                end
                else if (sts.walk_hit)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = ST_INVAL;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// File: hw/rtl/fbpa_dp.sv
module fbpa_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fbpa_pkg::fbpa_cfg_t           cfg,
    input  logic [fbpa_pkg::ADDR_W-1:0]   block_address,
    input  fbpa_pkg::fbpa_cmd_t           cmd,
    output fbpa_pkg::fbpa_sts_t           sts,
    output logic                          done,
    output logic [fbpa_pkg::ST_W-1:0]     status,
    output logic [fbpa_pkg::ADDR_W-1:0]   granted_address,
    output logic [fbpa_pkg::CNT_W-1:0]    free_count
);
    import fbpa_pkg::*;

    logic [LINK_W-1:0] link_mem [MAX_BLOCKS];
    logic [LINK_W-1:0] link_rd_reg;

    logic [ADDR_W-1:0] addr_reg;
    logic [LINK_W-1:0] bld_reg;
    logic [LINK_W-1:0] head_reg;
    logic [LINK_W-1:0] head_next;
    logic [LINK_W-1:0] total_reg;
    logic [LINK_W-1:0] total_next;
    logic              ready_reg;
    logic              ready_next;

    logic [PROD_W-1:0] prod_reg;
    logic [ADDR_W-1:0] off_reg;
    logic              lt_reg;

    logic [PROD_W-1:0] rem_reg;
    logic [PROD_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  q_reg;
    logic [DIVC_W-1:0] div_cnt_reg;

    logic              walk_first_reg;
    logic [LINK_W-1:0] steps_reg;

    logic              done_reg;
    logic [ST_W-1:0]   status_reg;
    logic [ADDR_W-1:0] granted_reg;
    logic [CNT_W-1:0]  free_count_reg;

    logic              bld_last;
    logic [LINK_W-1:0] bld_link;
    logic [WIDE_W-1:0] mul_a;
    logic [LINK_W-1:0] idx;
    logic [LINK_W-1:0] cur;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [LINK_W-1:0] mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    logic              div_ge;

    assign bld_last = (WIDE_W'(bld_reg) + WIDE_W'(1)) >= WIDE_W'(cfg.count);
    assign bld_link = bld_last ? NIL : bld_reg + LINK_W'(1);
    assign mul_a    = cmd.chk_setup ? WIDE_W'(cfg.count) : WIDE_W'(head_reg);
    assign idx      = LINK_W'(q_reg);
    assign cur      = walk_first_reg ? head_reg : link_rd_reg;
    assign div_ge   = (rem_reg >= dvs_reg);

    assign mem_we    = (cmd.bld_step || cmd.push);
    assign mem_waddr = cmd.push ? idx[IDX_W-1:0] : bld_reg[IDX_W-1:0];
    assign mem_wdata = cmd.push ? head_reg : bld_link;
    assign mem_re    = (cmd.mem_rd || cmd.walk_step);
    assign mem_raddr = cmd.walk_step ? cur[IDX_W-1:0] : head_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            link_rd_reg <= link_mem[mem_raddr];
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        total_next = total_reg;
        ready_next = ready_reg;
        if (cmd.bld_step && bld_last)
        begin
            head_next  = '0;
            total_next = LINK_W'(cfg.count);
            ready_next = 1'b1;
        end
        if (cmd.pop)
        begin
            head_next = link_rd_reg;
            if (total_reg != '0)
            begin
                total_next = total_reg - LINK_W'(1);
            end
        end
        if (cmd.push)
        begin
            head_next  = idx;
            total_next = total_reg + LINK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= NIL;
            total_reg <= '0;
            ready_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            total_reg <= total_next;
            ready_reg <= ready_next;
            done_reg  <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            addr_reg <= block_address;
            bld_reg  <= '0;
        end
        else if (cmd.bld_step)
        begin
            bld_reg <= bld_reg + LINK_W'(1);
        end

        if (cmd.mem_rd || cmd.chk_setup)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(cfg.size);
        end
        if (cmd.chk_setup)
        begin
            off_reg <= addr_reg - cfg.base;
            lt_reg  <= (addr_reg < cfg.base);
        end

        if (cmd.div_start)
        begin
            rem_reg     <= PROD_W'(off_reg);
            dvs_reg     <= PROD_W'(cfg.size) << (CNT_W - 1);
            q_reg       <= '0;
            div_cnt_reg <= DIVC_W'(CNT_W);
        end
        else if (cmd.div_step)
        begin
            if (div_ge)
            begin
                rem_reg <= rem_reg - dvs_reg;
            end
            q_reg       <= {q_reg[CNT_W-2:0], div_ge};
            dvs_reg     <= dvs_reg >> 1;
            div_cnt_reg <= div_cnt_reg - DIVC_W'(1);
        end

        if (cmd.walk_start)
        begin
            walk_first_reg <= 1'b1;
            steps_reg      <= '0;
        end
        else if (cmd.walk_step)
        begin
            walk_first_reg <= 1'b0;
            steps_reg      <= steps_reg + LINK_W'(1);
        end

        if (cmd.finish)
        begin
            status_reg     <= cmd.code;
            granted_reg    <= cmd.pop ? cfg.base + ADDR_W'(prod_reg) : '0;
            free_count_reg <= CNT_W'(total_next);
        end
    end

    always_comb
    begin
        sts.addr_zero  = (block_address == '0);
        sts.cfg_ok     = (cfg.base != '0) && (cfg.count != '0)
                         && (WIDE_W'(cfg.count) <= WIDE_W'(MAX_BLOCKS))
                         && (cfg.size >= SIZE_W'(PTR_BYTES))
                         && ((cfg.size % SIZE_W'(PTR_BYTES)) == '0);
        sts.ready      = ready_reg;
        sts.bld_last   = bld_last;
        sts.head_nil   = (head_reg >= NIL);
        sts.range_bad  = (cfg.base == '0) || (cfg.size == '0) || lt_reg
                         || (off_reg >= ADDR_W'(prod_reg));
        sts.div_last   = (div_cnt_reg == DIVC_W'(1));
        sts.div_bad    = (rem_reg != '0) || (WIDE_W'(q_reg) >= WIDE_W'(MAX_BLOCKS));
        sts.walk_end   = (cur >= NIL) || (steps_reg == LINK_W'(MAX_BLOCKS));
        sts.walk_hit   = (cur == idx);
        sts.total_full = (WIDE_W'(total_reg) >= WIDE_W'(cfg.count));
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign granted_address = granted_reg;
    assign free_count      = free_count_reg;

endmodule

// File: hw/rtl/fixed_block_pool_allocator.sv
// Channel   Handshake                       Payload
// request   start, accepted when busy low   action, block_address
// result    done, one cycle, no stall       status, granted_address, free_count
// config    APB write, pready tied high     paddr, pwdata (base, size, count)
//
// Allocate: S_DISP reads the head, S_ALLOC_POP pops it; an empty pool answers from S_DISP.
// Free: range check (S_FREE_CHK), bit-serial division (S_DIV, S_DIV_CHK), then the walk
// of the free list, which reads one link per cycle from the link memory.
// The first request with a valid configuration first builds the chain of block_count links.
// Reset clears control state; the link memory keeps no reset and is only read once written.
// The result is valid with done and holds until the next result; the receiver cannot stall it.
module fixed_block_pool_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fbpa_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          start,
    input  logic                          action,
    input  logic [fbpa_pkg::ADDR_W-1:0]   block_address,
    output logic                          busy,
    output logic                          done,
    output logic [fbpa_pkg::ST_W-1:0]     status,
    output logic [fbpa_pkg::ADDR_W-1:0]   granted_address,
    output logic [fbpa_pkg::CNT_W-1:0]    free_count
);
    import fbpa_pkg::*;

    logic [ADDR_W-1:0] base_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              wr_en;
    fbpa_cfg_t         cfg;
    fbpa_cmd_t         cmd;
    fbpa_sts_t         sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            size_reg  <= '0;
            count_reg <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[APB_AW-1:2])
                REG_BASE:  base_reg  <= pwdata;
                REG_SIZE:  size_reg  <= pwdata[SIZE_W-1:0];
                REG_COUNT: count_reg <= pwdata[CNT_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[APB_AW-1:2])
            REG_BASE:  prdata = base_reg;
            REG_SIZE:  prdata = 32'(size_reg);
            REG_COUNT: prdata = 32'(count_reg);
            default:   prdata = '0;
        endcase
    end

    assign cfg.base  = base_reg;
    assign cfg.size  = size_reg;
    assign cfg.count = count_reg;

    fbpa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    fbpa_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .block_address   (block_address),
        .cmd             (cmd),
        .sts             (sts),
        .done            (done),
        .status          (status),
        .granted_address (granted_address),
        .free_count      (free_count)
    );

    a_no_grant_on_fail: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (granted_address == '0)
    ) else $error("address granted on a failed transaction");

    a_accept_progress: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done)
    ) else $error("accepted transaction neither in progress nor answered");

    a_empty_count: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && status == ST_BUSY) |-> (free_count == '0)
    ) else $error("empty pool reported with free blocks");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import fbpa_pkg::*;

    localparam int N_DIR       = 39;
    localparam int SOAK_PHASES = 8;
    localparam int SOAK_ITEMS  = 175;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int TAIL_CYCLES = 300;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [ADDR_W-1:0] grant;
        logic [CNT_W-1:0]  fcount;
    } pool_reply_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  reg_idx;
        logic        act;
        logic [31:0] data;
        logic        typed;
        pool_reply_t answer;
    } dir_row_t;

    typedef struct {
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] size;
        logic [CNT_W-1:0]  count;
        int                idle_pct;
        int                alloc_pct;
    } soak_phase_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [APB_AW-1:0]   paddr         = '0;
    logic [31:0]         pwdata        = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                start         = 1'b0;
    logic                action        = ACT_ALLOC;
    logic [ADDR_W-1:0]   block_address = '0;
    logic                busy;
    logic                done;
    logic [ST_W-1:0]     status;
    logic [ADDR_W-1:0]   granted_address;
    logic [CNT_W-1:0]    free_count;

    logic [ADDR_W-1:0]   cfg_base  = '0;
    logic [SIZE_W-1:0]   cfg_size  = '0;
    logic [CNT_W-1:0]    cfg_count = '0;
    logic [LINK_W-1:0]   pool_link [MAX_BLOCKS];
    logic [LINK_W-1:0]   pool_head  = NIL;
    logic [CNT_W-1:0]    pool_total = '0;
    logic                pool_built = 1'b0;
    bit                  on_chain [MAX_BLOCKS];

    pool_reply_t         pending_replies [$];
    pool_reply_t         fresh_reply;
    pool_reply_t         want_reply;
    pool_reply_t         row_answer;
    logic                row_has_answer = 1'b0;
    int                  idle_pct = 0;
    int                  fault_cnt = 0;
    longint unsigned     cycle_cnt;

    dir_row_t            dir_plan [N_DIR];
    soak_phase_t         soak [SOAK_PHASES];

    fixed_block_pool_allocator uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .start           (start),
        .action          (action),
        .block_address   (block_address),
        .busy            (busy),
        .done            (done),
        .status          (status),
        .granted_address (granted_address),
        .free_count      (free_count)
    );

    always #5 clk = ~clk;

    task automatic pool_build(output logic ok);
        if (!pool_built && cfg_base != 0 && cfg_count != 0 && cfg_count <= MAX_BLOCKS &&
            cfg_size >= PTR_BYTES && (cfg_size % PTR_BYTES) == 0)
        begin
            for (int i = 0; i < cfg_count; i++)
            begin
                pool_link[i] = (i + 1 < cfg_count) ? LINK_W'(i + 1) : NIL;
            end
            pool_head  = '0;
            pool_total = cfg_count;
            pool_built = 1'b1;
        end
        ok = pool_built;
    endtask

    task automatic refresh_chain_marks();
        logic [LINK_W-1:0] cur;
        int                steps;
        foreach (on_chain[j])
        begin
            on_chain[j] = 1'b0;
        end
        cur   = pool_head;
        steps = 0;
        while (steps < MAX_BLOCKS && cur < MAX_BLOCKS)
        begin
            on_chain[cur[IDX_W-1:0]] = 1'b1;
            cur = pool_link[cur[IDX_W-1:0]];
            steps++;
        end
    endtask

    task automatic predict_pool_reply(input logic act, input logic [ADDR_W-1:0] addr,
                                      output pool_reply_t r);
        logic              ok;
        logic [LINK_W-1:0] slot;
        logic [63:0]       off;
        logic [63:0]       idx;
        r.status = ST_OK;
        r.grant  = '0;
        if (act == ACT_ALLOC)
        begin
            pool_build(ok);
            if (!ok)
                r.status = ST_INVAL;
            else if (pool_head >= MAX_BLOCKS)
                r.status = ST_BUSY;
            else
            begin
                slot      = pool_head;
                r.grant   = cfg_base + ADDR_W'(slot) * ADDR_W'(cfg_size);
                pool_head = pool_link[slot[IDX_W-1:0]];
                if (pool_total > 0)
                    pool_total = pool_total - 1'b1;
            end
        end
        else if (addr == 0)
            r.status = ST_INVAL;
        else
        begin
            pool_build(ok);
            if (!ok || cfg_base == 0 || cfg_size == 0 || addr < cfg_base)
                r.status = ST_INVAL;
            else
            begin
                off = 64'(addr) - 64'(cfg_base);
                idx = off / 64'(cfg_size);
                refresh_chain_marks();
                if (off >= 64'(cfg_size) * 64'(cfg_count))
                    r.status = ST_INVAL;
                else if ((off % 64'(cfg_size)) != 0)
                    r.status = ST_INVAL;
                else if (idx >= MAX_BLOCKS)
                    r.status = ST_INVAL;
                else if (on_chain[idx[IDX_W-1:0]])
                    r.status = ST_INVAL;
                else if (pool_total >= cfg_count)
                    r.status = ST_INVAL;
                else
                begin
                    pool_link[idx[IDX_W-1:0]] = pool_head;
                    pool_head  = LINK_W'(idx);
                    pool_total = pool_total + 1'b1;
                end
            end
        end
        if (r.status != ST_OK)
            r.grant = '0;
        r.fcount = pool_total;
    endtask

    task automatic pick_request(input int alloc_pct, output logic act,
                                output logic [ADDR_W-1:0] addr);
        int held [$];
        int listed [$];
        int lim;
        int roll;
        refresh_chain_marks();
        lim = (cfg_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(cfg_count);
        for (int i = 0; i < lim; i++)
        begin
            if (on_chain[i])
                listed.push_back(i);
            else
                held.push_back(i);
        end
        act  = ACT_FREE;
        addr = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct)
            act = ACT_ALLOC;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70 && held.size() > 0)
                addr = cfg_base + ADDR_W'(held[$urandom_range(0, held.size() - 1)]) *
                       ADDR_W'(cfg_size);
            else if (roll < 80 && listed.size() > 0)
                addr = cfg_base + ADDR_W'(listed[$urandom_range(0, listed.size() - 1)]) *
                       ADDR_W'(cfg_size);
            else if (roll < 87 && cfg_size > 1)
                addr = cfg_base + ADDR_W'($urandom_range(0, lim)) * ADDR_W'(cfg_size) +
                       ADDR_W'($urandom_range(1, cfg_size - 1));
            else if (roll < 93)
                addr = $urandom_range(0, 1) ? cfg_base + ADDR_W'(cfg_count) * ADDR_W'(cfg_size)
                                            : cfg_base - ADDR_W'($urandom_range(1, 64));
            else if (roll < 96)
                addr = '0;
        end
    endtask

    task automatic send_request(input logic act, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start         <= 1'b1;
        action        <= act;
        block_address <= addr;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_replies.size() != 0 || busy) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] reg_idx, input logic [31:0] value);
        logic [31:0] readback;
        logic [31:0] held_val;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (reg_idx)
            REG_BASE:  cfg_base  = value;
            REG_SIZE:  cfg_size  = value[SIZE_W-1:0];
            REG_COUNT: cfg_count = value[CNT_W-1:0];
            default:   ;
        endcase
        held_val = (reg_idx == REG_BASE) ? cfg_base :
                   (reg_idx == REG_SIZE) ? 32'(cfg_size) : 32'(cfg_count);
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        readback = prdata;
        if (readback !== held_val)
        begin
            $display("%0t: register %0d readback expected %h got %h",
                     $time, reg_idx, held_val, readback);
            fault_cnt++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected transaction status %0d address %h free %0d",
                         $time, status, granted_address, free_count);
                fault_cnt++;
            end
            else
            begin
                want_reply = pending_replies.pop_front();
                if (status !== want_reply.status)
                begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want_reply.status, status);
                    fault_cnt++;
                end
                if (granted_address !== want_reply.grant)
                begin
                    $display("%0t: granted_address expected %h got %h",
                             $time, want_reply.grant, granted_address);
                    fault_cnt++;
                end
                if (free_count !== want_reply.fcount)
                begin
                    $display("%0t: free_count expected %0d got %0d",
                             $time, want_reply.fcount, free_count);
                    fault_cnt++;
                end
            end
        end
        if (rst_n && start && !busy)
        begin
            predict_pool_reply(action, block_address, fresh_reply);
            pending_replies.push_back(row_has_answer ? row_answer : fresh_reply);
        end
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("%0t: timeout with %0d transactions outstanding", $time, pending_replies.size());
        $display("fixed_block_pool_allocator test failed");
        $finish;
    end

    initial
    begin
        logic              act_sel;
        logic [ADDR_W-1:0] addr_sel;

        foreach (pool_link[j])
        begin
            pool_link[j] = '0;
        end

        dir_plan = '{
            '{ROW_REQ, REG_BASE,  ACT_ALLOC, 32'h0000_0000, 1'b1, '{ST_INVAL, 32'h0, 9'd0}},
            '{ROW_REQ, REG_BASE,  ACT_FREE,  32'h0000_0000, 1'b1, '{ST_INVAL, 32'h0, 9'd0}},
            '{ROW_REQ, REG_BASE,  ACT_FREE,  32'hFFFF_FFFF, 1'b1, '{ST_INVAL, 32'h0, 9'd0}},
            '{ROW_CFG, REG_BASE,  ACT_ALLOC, 32'h0000_1000, 1'b0, '0},
            '{ROW_CFG, REG_SIZE,  ACT_ALLOC, 32'd2,         1'b0, '0},
            '{ROW_CFG, REG_COUNT, ACT_ALLOC, 32'd4,         1'b0, '0},
            '{ROW_REQ, REG_BASE,  ACT_ALLOC, 32'h0000_0000, 1'b1, '{ST_INVAL, 32'h0, 9'd0}},
            '{ROW_CFG, REG_SIZE,  ACT_ALLOC, 32'd6,         1'b0, '0},
            '{ROW_REQ, REG_BASE,  ACT_ALLOC, 32'h0000_0000, 1'b1, '{ST_INVAL, 32'h0, 9'd0}},
            '{ROW_CFG, REG_SIZE,  ACT_ALLOC, 32'd16,        1'b0, '0},
            '{ROW_CFG, REG_COUNT, ACT_ALLOC, 32'd300,       1'b0, '0},
            '{ROW_REQ, REG_BASE,  ACT_ALLOC, 32'h0000_0000, 1'b1, '{ST_INVAL, 32'h0, 9'd0}},
            '{ROW_CFG, REG_COUNT, ACT_ALLOC, 32'd4,         1'b0, '0},
            '{ROW_REQ, REG_BASE,  ACT_ALLOC, 32'h0000_0000, 1'b1, '{ST_OK, 32'h1000, 9'd3}},
            '{ROW_REQ, REG_BASE,  ACT_ALLOC, 32'h0000_0000, 1'b1, '{ST_OK, 32'h1010, 9'd2}},
            '{ROW_REQ, REG_BASE,  ACT_FREE,  32'h0000_1000, 1'b1, '{ST_OK, 32'h0, 9'd3}},
            '{ROW_REQ, REG_BASE,  ACT_FREE,  32'h0000_1000, 1'b1, '{ST_INVAL, 32'h0, 9'd3}},
            '{ROW_REQ, REG_BASE,  ACT_FREE,  32'h0000_1008, 1'b1, '{ST_INVAL, 32'h0, 9'd3}},
            '{ROW_REQ, REG_BASE,  ACT_FREE,  32'h0000_1040, 1'b1, '{ST_INVAL, 32'h0, 9'd3}},
            '{ROW_REQ, REG_BASE,  ACT_FREE,  32'h0000_0FF0, 1'b1, '{ST_INVAL, 32'h0, 9'd3}},
            '{ROW_REQ, REG_BASE,  ACT_FREE,  32'h0000_0000, 1'b1, '{ST_INVAL, 32'h0, 9'd3}},
            '{ROW_REQ, REG_BASE,  ACT_ALLOC, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'h1000, 9'd2}},
            '{ROW_REQ, REG_BASE,  ACT_ALLOC, 32'h0000_0000, 1'b1, '{ST_OK, 32'h1020, 9'd1}},
            '{ROW_REQ, REG_BASE,  ACT_ALLOC, 32'h0000_0000, 1'b1, '{ST_OK, 32'h1030, 9'd0}},
            '{ROW_REQ, REG_BASE,  ACT_ALLOC, 32'h0000_0000, 1'b1, '{ST_BUSY, 32'h0, 9'd0}},
            '{ROW_REQ, REG_BASE,  ACT_FREE,  32'h0000_1030, 1'b0, '0},
            '{ROW_REQ, REG_BASE,  ACT_FREE,  32'h0000_1010, 1'b0, '0},
            '{ROW_CFG, REG_COUNT, ACT_ALLOC, 32'd2,         1'b0, '0},
            '{ROW_REQ, REG_BASE,  ACT_FREE,  32'h0000_1000, 1'b1, '{ST_INVAL, 32'h0, 9'd2}},
            '{ROW_CFG, REG_BASE,  ACT_ALLOC, 32'hFFFF_FFF0, 1'b0, '0},
            '{ROW_CFG, REG_COUNT, ACT_ALLOC, 32'd4,         1'b0, '0},
            '{ROW_REQ, REG_BASE,  ACT_ALLOC, 32'h0000_0000, 1'b0, '0},
            '{ROW_CFG, REG_BASE,  ACT_ALLOC, 32'h0000_1000, 1'b0, '0},
            '{ROW_CFG, REG_SIZE,  ACT_ALLOC, 32'd4,         1'b0, '0},
            '{ROW_CFG, REG_COUNT, ACT_ALLOC, 32'd300,       1'b0, '0},
            '{ROW_REQ, REG_BASE,  ACT_FREE,  32'h0000_1400, 1'b1, '{ST_INVAL, 32'h0, 9'd1}},
            '{ROW_CFG, REG_SIZE,  ACT_ALLOC, 32'd0,         1'b0, '0},
            '{ROW_REQ, REG_BASE,  ACT_FREE,  32'h0000_1000, 1'b1, '{ST_INVAL, 32'h0, 9'd1}},
            '{ROW_REQ, REG_BASE,  ACT_ALLOC, 32'h0000_0000, 1'b0, '0}
        };

        soak = '{
            '{32'h2000_0000, 16'd4,     9'd256, 0,  50},
            '{32'h8000_0000, 16'd64,    9'd256, 48, 40},
            '{32'hFFFF_0000, 16'd65532, 9'd8,   14, 55},
            '{32'h0000_0004, 16'd8,     9'd1,   0,  50},
            '{32'hFFFF_FFFF, 16'd65535, 9'd256, 48, 45},
            '{32'h0000_0000, 16'd16,    9'd128, 14, 60},
            '{32'h1234_5670, 16'd12,    9'd200, 0,  45},
            '{32'h4000_0000, 16'd4,     9'd256, 48, 35}
        };

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++)
        begin
            if (dir_plan[i].kind == ROW_CFG)
            begin
                settle();
                cfg_write(dir_plan[i].reg_idx, dir_plan[i].data);
            end
            else
            begin
                @(negedge clk);
                row_has_answer = dir_plan[i].typed;
                row_answer     = dir_plan[i].answer;
                send_request(dir_plan[i].act, dir_plan[i].data);
            end
        end

        row_has_answer = 1'b0;
        for (int p = 0; p < SOAK_PHASES; p++)
        begin
            settle();
            cfg_write(REG_BASE,  soak[p].base);
            cfg_write(REG_SIZE,  32'(soak[p].size));
            cfg_write(REG_COUNT, 32'(soak[p].count));
            idle_pct = soak[p].idle_pct;
            for (int k = 0; k < SOAK_ITEMS; k++)
            begin
                // hold the request side until every transaction has drained
                if (p == 1 && k == SOAK_ITEMS / 2)
                    settle();
                @(negedge clk);
                pick_request(soak[p].alloc_pct, act_sel, addr_sel);
                send_request(act_sel, addr_sel);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_replies.size() != 0)
        begin
            $display("%0t: %0d transactions never completed", $time, pending_replies.size());
            fault_cnt++;
        end
        if (fault_cnt == 0)
            $display("fixed_block_pool_allocator test passed");
        else
            $display("fixed_block_pool_allocator test failed");
        $finish;
    end

endmodule
